// ===== src/mlft_pkg.sv =====
// shared constants and types for the mac learning forwarding table
// no dependencies; imported by mlft_cell and mac_learning_forwarding_table
package mlft_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int MAX_PORTS   = 8;

    localparam int MAC_W  = 48;
    localparam int PORT_W = 3;
    localparam int MASK_W = 8;
    localparam int CNT_W  = 4;

    localparam logic [CNT_W-1:0] ACTIVE_PORTS_RESET = CNT_W'(8);

    // broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic cmp;      // compare stored mac with the key, register the match
        logic wr_port;  // matching cell takes the new port
        logic shift;    // every cell takes its left neighbor's entry
    } cell_ctrl_t;

endpackage

// ===== src/mlft_cell.sv =====
// one table entry of the learning chain: valid, mac, port and a match flag
// depends on mlft_pkg
module mlft_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mlft_pkg::cell_ctrl_t         ctrl,
    input  logic [mlft_pkg::MAC_W-1:0]   key,
    input  logic [mlft_pkg::PORT_W-1:0]  new_port,
    input  logic                         prev_valid,
    input  logic [mlft_pkg::MAC_W-1:0]   prev_mac,
    input  logic [mlft_pkg::PORT_W-1:0]  prev_port,
    output logic                         valid,
    output logic [mlft_pkg::MAC_W-1:0]   mac,
    output logic [mlft_pkg::PORT_W-1:0]  port,
    output logic                         match,
    output logic [mlft_pkg::MASK_W-1:0]  port_mask
);
    import mlft_pkg::*;

    logic                valid_reg;
    logic [MAC_W-1:0]    mac_reg;
    logic [PORT_W-1:0]   port_reg;
    logic                match_reg;
    logic [MASK_W-1:0]   port_mask_reg;
    logic                match_next;

    assign match_next = valid_reg && (mac_reg == key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.shift)
            begin
                valid_reg <= prev_valid;
            end
            if (ctrl.cmp)
            begin
                match_reg <= match_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            mac_reg  <= prev_mac;
            port_reg <= prev_port;
        end
        else if (ctrl.wr_port && match_reg)
        begin
            port_reg <= new_port;
        end
        if (ctrl.cmp)
        begin
            port_mask_reg <= match_next ? (MASK_W'(1) << port_reg) : '0;
        end
    end

    assign valid     = valid_reg;
    assign mac       = mac_reg;
    assign port      = port_reg;
    assign match     = match_reg;
    assign port_mask = port_mask_reg;

endmodule

// ===== src/mac_learning_forwarding_table.sv =====
// top level of the learning bridge mac table: sequencer, cell chain, flood logic
// depends on mlft_pkg and mlft_cell
//
//  channel   handshake            payload
//  request   start & !busy        source_mac, dest_mac, ingress_port
//  result    done (one cycle)     egress_mask, flooded, source_learned, table_full
//  config    cfg_wr_en            cfg_wr_data (active_ports)
//
// a request passes from acceptance to the done strobe through source compare,
// table update, destination compare, match reduction, then the result cycle
// a new request is taken in the cycle that done is high
// reset clears all valid bits at once; active_ports resets to 8
// the receiver cannot stall, so done is never held off
module mac_learning_forwarding_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mlft_pkg::MAC_W-1:0]   source_mac,
    input  logic [mlft_pkg::MAC_W-1:0]   dest_mac,
    input  logic [mlft_pkg::PORT_W-1:0]  ingress_port,
    input  logic                         cfg_wr_en,
    input  logic [mlft_pkg::CNT_W-1:0]   cfg_wr_data,
    output logic                         done,
    output logic [mlft_pkg::MASK_W-1:0]  egress_mask,
    output logic                         flooded,
    output logic                         source_learned,
    output logic                         table_full
);
    import mlft_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_CMP_SRC = 5'b00010,
        ST_UPDATE  = 5'b00100,
        ST_CMP_DST = 5'b01000,
        ST_REDUCE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // request held for the whole lookup
    logic [MAC_W-1:0]  src_reg;
    logic [MAC_W-1:0]  dst_reg;
    logic [PORT_W-1:0] in_port_reg;

    logic [CNT_W-1:0]  active_ports_reg;

    logic              learned_reg;
    logic              full_reg;

    logic              done_reg;
    logic [MASK_W-1:0] egress_mask_reg;
    logic              flooded_reg;
    logic              source_learned_reg;
    logic              table_full_reg;

    // chain wiring, one element per cell
    logic               cell_valid [TABLE_DEPTH];
    logic [MAC_W-1:0]   cell_mac   [TABLE_DEPTH];
    logic [PORT_W-1:0]  cell_port  [TABLE_DEPTH];
    logic               cell_match [TABLE_DEPTH];
    logic [MASK_W-1:0]  cell_mask  [TABLE_DEPTH];

    cell_ctrl_t         ctrl;
    logic [MAC_W-1:0]   key;
    logic               any_match;
    logic [MASK_W-1:0]  hit_mask;
    logic               chain_full;
    logic [CNT_W-1:0]   count_lim;
    logic [MASK_W-1:0]  flood_mask;
    logic               accept;

    assign accept     = start && !busy;
    assign busy       = (state_reg != ST_IDLE);
    // entries are never removed, so the chain fills from the head;
    // once the tail cell holds an entry there is no room left
    assign chain_full = cell_valid[TABLE_DEPTH-1];

    // the entries are distinct, so at most one cell matches and a plain or
    // of the match flags and port masks gives the hit
    always_comb
    begin
        any_match = 1'b0;
        hit_mask  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            any_match = any_match | cell_match[i];
            hit_mask  = hit_mask | cell_mask[i];
        end
    end

    // flood to active ports below the limit, leaving out the ingress port
    always_comb
    begin
        count_lim = (active_ports_reg > CNT_W'(MAX_PORTS)) ? CNT_W'(MAX_PORTS)
                                                          : active_ports_reg;
        for (int i = 0; i < MASK_W; i++)
        begin
            flood_mask[i] = (CNT_W'(i) < count_lim) && (PORT_W'(i) != in_port_reg);
        end
    end

    always_comb
    begin
        ctrl.cmp     = (state_reg == ST_CMP_SRC) || (state_reg == ST_CMP_DST);
        ctrl.wr_port = (state_reg == ST_UPDATE);
        ctrl.shift   = (state_reg == ST_UPDATE) && !any_match && !chain_full;
        key          = (state_reg == ST_CMP_DST) ? dst_reg : src_reg;
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:    state_next = accept ? ST_CMP_SRC : ST_IDLE;
            ST_CMP_SRC: state_next = ST_UPDATE;
            ST_UPDATE:  state_next = ST_CMP_DST;
            ST_CMP_DST: state_next = ST_REDUCE;
            ST_REDUCE:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            active_ports_reg <= ACTIVE_PORTS_RESET;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_REDUCE);
            if (cfg_wr_en)
            begin
                active_ports_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg     <= source_mac;
            dst_reg     <= dest_mac;
            in_port_reg <= ingress_port;
        end
        // source outcome is settled in the update cycle
        if (state_reg == ST_UPDATE)
        begin
            learned_reg <= !any_match && !chain_full;
            full_reg    <= !any_match && chain_full;
        end
        if (state_reg == ST_REDUCE)
        begin
            egress_mask_reg    <= any_match ? hit_mask : flood_mask;
            flooded_reg        <= !any_match;
            source_learned_reg <= learned_reg;
            table_full_reg     <= full_reg;
        end
    end

    // head of the chain: a newly learned source enters cell 0 and the
    // others move one place toward the tail
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            logic              prev_valid;
            logic [MAC_W-1:0]  prev_mac;
            logic [PORT_W-1:0] prev_port;

            if (g == 0)
            begin : g_head
                assign prev_valid = 1'b1;
                assign prev_mac   = src_reg;
                assign prev_port  = in_port_reg;
            end
            else
            begin : g_body
                assign prev_valid = cell_valid[g-1];
                assign prev_mac   = cell_mac[g-1];
                assign prev_port  = cell_port[g-1];
            end

            mlft_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .key        (key),
                .new_port   (in_port_reg),
                .prev_valid (prev_valid),
                .prev_mac   (prev_mac),
                .prev_port  (prev_port),
                .valid      (cell_valid[g]),
                .mac        (cell_mac[g]),
                .port       (cell_port[g]),
                .match      (cell_match[g]),
                .port_mask  (cell_mask[g])
            );
        end
    endgenerate

    assign done           = done_reg;
    assign egress_mask    = egress_mask_reg;
    assign flooded        = flooded_reg;
    assign source_learned = source_learned_reg;
    assign table_full     = table_full_reg;

endmodule
